// File: rtl/tam_pkg.sv
// Shared types, constants and the arctangent step table of the tilt angle averager.
// Depends on nothing; the core, tam_front and tam_back import it.
package tam_pkg;

	localparam int SAMPLE_W = 12;
	localparam int ANGLE_W = 16;
	localparam int CORDIC_ITERS = 16;
	localparam int CW = 29;
	localparam int ZW = 28;
	localparam int IN_SCALE = 14;
	localparam int FRAC_SHIFT = 12;
	localparam int DEG180 = 47185920;
	localparam int ANG_LIMIT = 11520;
	localparam int QUARTER = 5760;
	localparam int WINDOW_DEFAULT = 20;
	localparam int QUEUE_DEPTH_DEFAULT = 4;
	localparam int LANES = 2;
	localparam int LANE_XY = 0;
	localparam int LANE_XZ = 1;

	typedef logic signed [ANGLE_W-1:0] angle_t;

	typedef struct packed {
		angle_t xy;
		angle_t xz;
	} angle_pair_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	// Angle of one micro-rotation, in 1/262144 degree.
	function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
		logic signed [ZW-1:0] a;
		unique case (i)
			0: a = ZW'(11796480);
			1: a = ZW'(6963869);
			2: a = ZW'(3679517);
			3: a = ZW'(1867780);
			4: a = ZW'(937515);
			5: a = ZW'(469214);
			6: a = ZW'(234664);
			7: a = ZW'(117339);
			8: a = ZW'(58671);
			9: a = ZW'(29335);
			10: a = ZW'(14668);
			11: a = ZW'(7334);
			12: a = ZW'(3667);
			13: a = ZW'(1833);
			14: a = ZW'(917);
			15: a = ZW'(458);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/tilt_angle_moving_average_core.sv
// Top level of the tilt angle moving average: CORDIC front end, queue, averaging back end,
// result queue. Depends on tam_pkg, tam_front, tam_fifo and tam_back.
//
//  Channel   Handshake      Payload                       Accepted when
//  ------    ---------      -------                       -------------
//  sample    push / full    accel_x, accel_y, accel_z     push high and full low
//  result    empty / pop    tilt_xy_avg, tilt_xz_avg      pop high and empty low
//
// One request is taken in every cycle while full is low, and each gives one result, shown
// with empty low once it has passed the CORDIC (operands prepared at the accepting edge,
// sixteen micro-rotations and rounding), the middle queue, the averaging stages and the
// result queue. Reset clears the window at once through per-entry valid bits.
// When the result queue fills, the back end stops and the middle queue takes the requests
// leaving the CORDIC; once that queue is full, full rises and the front halts.
module tilt_angle_moving_average_core #(
	parameter int WINDOW = tam_pkg::WINDOW_DEFAULT,
	parameter int QUEUE_DEPTH = tam_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [tam_pkg::SAMPLE_W-1:0] accel_x,
	input  logic signed [tam_pkg::SAMPLE_W-1:0] accel_y,
	input  logic signed [tam_pkg::SAMPLE_W-1:0] accel_z,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [tam_pkg::ANGLE_W-1:0]  tilt_xy_avg,
	output logic signed [tam_pkg::ANGLE_W-1:0]  tilt_xz_avg
);

	import tam_pkg::*;

	localparam int PAIR_W = $bits(angle_pair_t);

	logic front_en;
	logic front_valid;
	angle_pair_t front_pair;
	logic mid_full, mid_empty, mid_pop;
	logic [PAIR_W-1:0] mid_dout;
	logic back_push, res_full;
	angle_pair_t back_pair;
	logic [PAIR_W-1:0] res_dout;
	angle_pair_t res_pair;

	// The whole CORDIC pipeline advances together; it only stops when the middle queue
	// is full.
	assign front_en = !mid_full;
	assign full = !front_en;

	tam_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (front_en),
		.in_valid  (push && front_en),
		.x         (accel_x),
		.y         (accel_y),
		.z         (accel_z),
		.out_valid (front_valid),
		.out_pair  (front_pair)
	);

	tam_fifo #(
		.WIDTH (PAIR_W),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_valid && front_en),
		.din    (front_pair),
		.full   (mid_full),
		.pop    (mid_pop),
		.dout   (mid_dout),
		.empty  (mid_empty)
	);

	tam_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!mid_empty),
		.in_pop   (mid_pop),
		.in_pair  (angle_pair_t'(mid_dout)),
		.out_full (res_full),
		.out_push (back_push),
		.out_pair (back_pair)
	);

	tam_fifo #(
		.WIDTH (PAIR_W),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (back_push),
		.din    (back_pair),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_dout),
		.empty  (empty)
	);

	assign res_pair = angle_pair_t'(res_dout);
	assign tilt_xy_avg = res_pair.xy;
	assign tilt_xz_avg = res_pair.xz;

endmodule

// File: rtl/tam_fifo.sv
// Small first-in first-out queue built from registers.
// Depends on nothing but its parameters.
module tam_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

endmodule

// File: rtl/tam_front.sv
// Front end: pipelined CORDIC vectoring for both tilt angles, one stage per iteration.
// Depends on tam_pkg for widths, constants and the step table.
module tam_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [tam_pkg::SAMPLE_W-1:0] x,
	input  logic signed [tam_pkg::SAMPLE_W-1:0] y,
	input  logic signed [tam_pkg::SAMPLE_W-1:0] z,
	output logic                                out_valid,
	output tam_pkg::angle_pair_t                out_pair
);

	import tam_pkg::*;

	// Index 0 holds the prepared operands, index k the state after k micro-rotations.
	logic    v_s    [CORDIC_ITERS+1];
	cordic_t c_s    [LANES][CORDIC_ITERS+1];
	logic    zero_s [LANES][CORDIC_ITERS+1];
	angle_t  ang_s2 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= CORDIC_ITERS; k++)
				v_s[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 0; k < CORDIC_ITERS; k++)
				v_s[k+1] <= v_s[k];
			out_valid <= v_s[CORDIC_ITERS];
		end
	end

	genvar l, k;
	generate
		for (l = 0; l < LANES; l++) begin : g_lane
			logic signed [SAMPLE_W-1:0] den;
			logic signed [CW-1:0] den_e, num_e;
			cordic_t pre;
			logic signed [ZW-1:0] z_rnd, z_cl;

			if (l == LANE_XY) begin : g_den_y
				assign den = y;
			end else begin : g_den_z
				assign den = z;
			end

			// Fold the left half plane onto the right one, starting such points from +/-180 degrees.
			always_comb begin
				den_e = CW'(den);
				num_e = CW'(x);
				pre.z = '0;
				if (den < 0) begin
					pre.z = (x >= 0) ? ZW'(DEG180) : -ZW'(DEG180);
					den_e = -den_e;
					num_e = -num_e;
				end
				pre.x = den_e <<< IN_SCALE;
				pre.y = num_e <<< IN_SCALE;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					c_s[l][0] <= pre;
					zero_s[l][0] <= (x == '0) && (den == '0);
				end
			end

			for (k = 0; k < CORDIC_ITERS; k++) begin : g_iter
				cordic_t cur, nxt;
				always_comb begin
					cur = c_s[l][k];
					if (!cur.y[CW-1]) begin
						nxt.x = cur.x + (cur.y >>> k);
						nxt.y = cur.y - (cur.x >>> k);
						nxt.z = cur.z + atan_step(k);
					end else begin
						nxt.x = cur.x - (cur.y >>> k);
						nxt.y = cur.y + (cur.x >>> k);
						nxt.z = cur.z - atan_step(k);
					end
				end
				always_ff @(posedge clk) begin
					if (en) begin
						c_s[l][k+1] <= nxt;
						zero_s[l][k+1] <= zero_s[l][k];
					end
				end
			end

			// Round half up to 1/64 degree, clamp to +/-180 degrees, then take off 90.
			always_comb begin
				z_rnd = (c_s[l][CORDIC_ITERS].z + ZW'(1 << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
				z_cl = z_rnd;
				if (z_rnd > ZW'(ANG_LIMIT))
					z_cl = ZW'(ANG_LIMIT);
				else if (z_rnd < -ZW'(ANG_LIMIT))
					z_cl = -ZW'(ANG_LIMIT);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					if (zero_s[l][CORDIC_ITERS])
						ang_s2[l] <= -ANGLE_W'(QUARTER);
					else
						ang_s2[l] <= ANGLE_W'(z_cl - ZW'(QUARTER));
				end
			end
		end
	endgenerate

	assign out_pair.xy = ang_s2[LANE_XY];
	assign out_pair.xz = ang_s2[LANE_XZ];

endmodule

// File: rtl/tam_back.sv
// Back end: ring buffer, running sums and the division by the window length.
// Depends on tam_pkg for the angle types.
module tam_back #(
	parameter int WINDOW = tam_pkg::WINDOW_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_pop,
	input  tam_pkg::angle_pair_t in_pair,
	input  logic                 out_full,
	output logic                 out_push,
	output tam_pkg::angle_pair_t out_pair
);

	import tam_pkg::*;

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W = ANGLE_W + $clog2(WINDOW);
	localparam int MAG_W = SUM_W - 1;
	localparam int PROD_W = 2 * MAG_W + 1;
	localparam logic [MAG_W:0] RECIP = (MAG_W + 1)'((64'(1) << MAG_W) / WINDOW);

	logic en;
	logic [SLOT_W-1:0] slot_q, slot_nx;
	logic [WINDOW-1:0] ent_vld_q;
	angle_pair_t mem_q [WINDOW];
	angle_pair_t rd_q, byp_val_q, old_pair;
	logic byp_q, live_q;
	logic v_s1, v_s2, v_s3;
	angle_t new_a [LANES];
	angle_t old_a [LANES];
	angle_t res_a [LANES];

	assign en = !out_full;
	assign in_pop = en && in_valid;
	assign out_push = en && v_s3;
	assign slot_nx = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);

	// The entry leaving the window was fetched one request ahead; a slot never written reads zero.
	assign old_pair = byp_q ? byp_val_q : (live_q ? rd_q : '0);
	assign new_a[LANE_XY] = in_pair.xy;
	assign new_a[LANE_XZ] = in_pair.xz;
	assign old_a[LANE_XY] = old_pair.xy;
	assign old_a[LANE_XZ] = old_pair.xz;
	assign out_pair.xy = res_a[LANE_XY];
	assign out_pair.xz = res_a[LANE_XZ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			ent_vld_q <= '0;
			byp_q <= 1'b0;
			live_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (in_pop) begin
				ent_vld_q[slot_q] <= 1'b1;
				slot_q <= slot_nx;
				byp_q <= (slot_nx == slot_q);
				live_q <= ent_vld_q[slot_nx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			mem_q[slot_q] <= in_pair;
			rd_q <= mem_q[slot_nx];
			byp_val_q <= in_pair;
		end
	end

	genvar l;
	generate
		for (l = 0; l < LANES; l++) begin : g_lane
			logic signed [SUM_W-1:0] sum_q, sum_abs;
			logic [PROD_W-1:0] prod_s2;
			logic [MAG_W-1:0] mag_s2, mag_s3;
			logic neg_s2, neg_s3;
			logic [ANGLE_W-1:0] q0_s3, q_fix;
			logic [MAG_W:0] qw_s3, rem;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					sum_q <= '0;
				else if (in_pop)
					sum_q <= sum_q - SUM_W'(old_a[l]) + SUM_W'(new_a[l]);
			end

			assign sum_abs = sum_q[SUM_W-1] ? -sum_q : sum_q;

			// Quotient by reciprocal; the estimate is exact or one short.
			always_ff @(posedge clk) begin
				if (en) begin
					neg_s2 <= sum_q[SUM_W-1];
					mag_s2 <= sum_abs[MAG_W-1:0];
					prod_s2 <= PROD_W'(sum_abs[MAG_W-1:0]) * PROD_W'(RECIP);
					neg_s3 <= neg_s2;
					mag_s3 <= mag_s2;
					q0_s3 <= prod_s2[MAG_W +: ANGLE_W];
					qw_s3 <= (MAG_W + 1)'(prod_s2[MAG_W +: ANGLE_W]) * (MAG_W + 1)'(WINDOW);
				end
			end

			always_comb begin
				rem = (MAG_W + 1)'(mag_s3) - qw_s3;
				q_fix = q0_s3;
				if (rem >= (MAG_W + 1)'(WINDOW))
					q_fix = q0_s3 + ANGLE_W'(1);
				res_a[l] = neg_s3 ? -angle_t'(q_fix) : angle_t'(q_fix);
			end
		end
	endgenerate

endmodule
